@@ hw/rtl/rsl_pkg.sv @@
package rsl_pkg;

   localparam int STATUS_BITS = 2;

   // result status codes
   localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;

   // command codes
   localparam logic CMD_JOIN   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   // running search flags carried down the cell chain
   typedef struct packed {
      logic member;      // some stored id equals the key
      logic any;         // some other member seen, mn and mx are live
      logic has_lo;      // lo holds the largest member below the key
      logic has_hi;      // hi holds the smallest member above the key
      logic free_found;  // free_idx holds the lowest free slot
   } flags_type;

endpackage

@@ hw/rtl/rsl_cell.sv @@
module rsl_cell #(
   parameter int KEY_BITS = 16,
   parameter int IDX_BITS = 5,
   parameter int CELL_IDX = 0
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    in_valid,
   input  logic                    in_cmd,
   input  logic [KEY_BITS-1:0]     in_key,
   input  rsl_pkg::flags_type      in_flags,
   input  logic [KEY_BITS-1:0]     in_mn,
   input  logic [KEY_BITS-1:0]     in_mx,
   input  logic [KEY_BITS-1:0]     in_lo,
   input  logic [KEY_BITS-1:0]     in_hi,
   input  logic [IDX_BITS-1:0]     in_free_idx,
   output logic                    out_valid,
   output logic                    out_cmd,
   output logic [KEY_BITS-1:0]     out_key,
   output rsl_pkg::flags_type      out_flags,
   output logic [KEY_BITS-1:0]     out_mn,
   output logic [KEY_BITS-1:0]     out_mx,
   output logic [KEY_BITS-1:0]     out_lo,
   output logic [KEY_BITS-1:0]     out_hi,
   output logic [IDX_BITS-1:0]     out_free_idx,
   input  logic                    wr_en,
   input  logic [IDX_BITS-1:0]     wr_idx,
   input  logic [KEY_BITS-1:0]     wr_key
);
   import rsl_pkg::*;

   logic                slot_live;
   logic [KEY_BITS-1:0] slot_id_ff;
   logic                slot_valid_ff;
   logic                write_hit;

   logic                valid_ff;
   logic                cmd_ff;
   logic [KEY_BITS-1:0] key_ff;
   flags_type           flags_ff, flags_in;
   logic [KEY_BITS-1:0] mn_ff, mn_in;
   logic [KEY_BITS-1:0] mx_ff, mx_in;
   logic [KEY_BITS-1:0] lo_ff, lo_in;
   logic [KEY_BITS-1:0] hi_ff, hi_in;
   logic [IDX_BITS-1:0] free_idx_ff, free_idx_in;
   logic                eq;

   assign write_hit = wr_en && (wr_idx == IDX_BITS'(CELL_IDX));
   assign slot_live = slot_valid_ff;
   assign eq        = (slot_id_ff == in_key);

   // fold this slot into the running search
   always_comb begin
      flags_in    = in_flags;
      mn_in       = in_mn;
      mx_in       = in_mx;
      lo_in       = in_lo;
      hi_in       = in_hi;
      free_idx_in = in_free_idx;
      if (slot_live) begin
         if (eq) begin
            flags_in.member = 1'b1;
         end else begin
            if (!in_flags.any || slot_id_ff < in_mn) begin
               mn_in = slot_id_ff;
            end
            if (!in_flags.any || slot_id_ff > in_mx) begin
               mx_in = slot_id_ff;
            end
            flags_in.any = 1'b1;
            if (slot_id_ff < in_key && (!in_flags.has_lo || slot_id_ff > in_lo)) begin
               lo_in           = slot_id_ff;
               flags_in.has_lo = 1'b1;
            end
            if (slot_id_ff > in_key && (!in_flags.has_hi || slot_id_ff < in_hi)) begin
               hi_in           = slot_id_ff;
               flags_in.has_hi = 1'b1;
            end
         end
      end else if (!in_flags.free_found) begin
         flags_in.free_found = 1'b1;
         free_idx_in         = IDX_BITS'(CELL_IDX);
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else if (write_hit) begin
         slot_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (write_hit) begin
         slot_id_ff <= wr_key;
      end
   end

   // hand the search to the next cell
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= in_cmd;
      key_ff      <= in_key;
      flags_ff    <= flags_in;
      mn_ff       <= mn_in;
      mx_ff       <= mx_in;
      lo_ff       <= lo_in;
      hi_ff       <= hi_in;
      free_idx_ff <= free_idx_in;
   end

   assign out_valid    = valid_ff;
   assign out_cmd      = cmd_ff;
   assign out_key      = key_ff;
   assign out_flags    = flags_ff;
   assign out_mn       = mn_ff;
   assign out_mx       = mx_ff;
   assign out_lo       = lo_ff;
   assign out_hi       = hi_ff;
   assign out_free_idx = free_idx_ff;

endmodule

@@ hw/rtl/ring_successor_lookup_table_unit.sv @@
// Ring successor lookup table.
// Holds up to MAX_MEMBERS identifiers as a ring ordered by value.
// Request channel (req_valid/req_ready): req_cmd selects join (0) or lookup (1),
// req_key carries the identifier to join or the key to look up.
// Response channel (rsp_valid/rsp_ready): one transaction per request, carrying
// status, owner, pred_id, succ_id, already_member and member_count.
// Each stored identifier lives in one cell of a chain; a request walks the chain
// one cell per cycle, gathering neighbors, owner, membership and the lowest free
// slot. At the tail the table is updated and the result is formed.
// The block holds one request at a time: req_ready drops while a request is in
// flight, and rises again once its result leaves the pending stage for the output
// register.
// A finished response waits in the output register while the receiver stalls,
// and a new request is taken meanwhile; its result then waits in the pending
// stage until the output register frees.
// Reset clears every slot's valid bit and the member count; the
// block takes requests in the first cycle after reset.
module ring_successor_lookup_table_unit #(
   parameter int MAX_MEMBERS = 32,
   parameter int KEY_BITS    = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic                                  req_cmd,
   input  logic [KEY_BITS-1:0]                   req_key,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [rsl_pkg::STATUS_BITS-1:0]       rsp_status,
   output logic [KEY_BITS-1:0]                   rsp_owner,
   output logic [KEY_BITS-1:0]                   rsp_pred_id,
   output logic [KEY_BITS-1:0]                   rsp_succ_id,
   output logic                                  rsp_already_member,
   output logic [$clog2(MAX_MEMBERS+1)-1:0]      rsp_member_count
);
   import rsl_pkg::*;

   localparam int IDX_BITS = $clog2(MAX_MEMBERS);
   localparam int CNT_BITS = $clog2(MAX_MEMBERS + 1);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   // chain taps: index 0 is the request register, index MAX_MEMBERS the tail
   logic                chain_valid    [MAX_MEMBERS+1];
   logic                chain_cmd      [MAX_MEMBERS+1];
   logic [KEY_BITS-1:0] chain_key      [MAX_MEMBERS+1];
   flags_type           chain_flags    [MAX_MEMBERS+1];
   logic [KEY_BITS-1:0] chain_mn       [MAX_MEMBERS+1];
   logic [KEY_BITS-1:0] chain_mx       [MAX_MEMBERS+1];
   logic [KEY_BITS-1:0] chain_lo       [MAX_MEMBERS+1];
   logic [KEY_BITS-1:0] chain_hi       [MAX_MEMBERS+1];
   logic [IDX_BITS-1:0] chain_free_idx [MAX_MEMBERS+1];

   logic                state_ff, state_in;
   logic                head_valid_ff;
   logic                head_cmd_ff;
   logic [KEY_BITS-1:0] head_key_ff;
   logic [CNT_BITS-1:0] count_ff, count_in;

   logic                pend_valid_ff;
   logic [STATUS_BITS-1:0] pend_status_ff, pend_status_in;
   logic [KEY_BITS-1:0] pend_owner_ff, pend_owner_in;
   logic [KEY_BITS-1:0] pend_pred_ff, pend_pred_in;
   logic [KEY_BITS-1:0] pend_succ_ff, pend_succ_in;
   logic                pend_already_ff, pend_already_in;

   logic                rsp_valid_ff;
   logic [STATUS_BITS-1:0] rsp_status_ff;
   logic [KEY_BITS-1:0] rsp_owner_ff;
   logic [KEY_BITS-1:0] rsp_pred_ff;
   logic [KEY_BITS-1:0] rsp_succ_ff;
   logic                rsp_already_ff;
   logic [CNT_BITS-1:0] rsp_count_ff;
   logic [CNT_BITS-1:0] pend_count_ff;

   logic                req_take;
   logic                tail_valid;
   logic                pend_move;
   logic                table_full;
   logic                insert;
   flags_type           tail_flags;

   assign req_ready = (state_ff == ST_IDLE);
   assign req_take  = req_valid && req_ready;

   // head of the chain: latch the request with a clean search record
   always_ff @(posedge clock) begin
      if (reset) begin
         head_valid_ff <= 1'b0;
      end else begin
         head_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         head_cmd_ff <= req_cmd;
         head_key_ff <= req_key;
      end
   end

   assign chain_valid[0]    = head_valid_ff;
   assign chain_cmd[0]      = head_cmd_ff;
   assign chain_key[0]      = head_key_ff;
   assign chain_flags[0]    = '0;
   assign chain_mn[0]       = '0;
   assign chain_mx[0]       = '0;
   assign chain_lo[0]       = '0;
   assign chain_hi[0]       = '0;
   assign chain_free_idx[0] = '0;

   genvar gi;
   generate
      for (gi = 0; gi < MAX_MEMBERS; gi++) begin : g_cell
         rsl_cell #(
            .KEY_BITS (KEY_BITS),
            .IDX_BITS (IDX_BITS),
            .CELL_IDX (gi)
         ) u_cell (
            .clock        (clock),
            .reset        (reset),
            .in_valid     (chain_valid[gi]),
            .in_cmd       (chain_cmd[gi]),
            .in_key       (chain_key[gi]),
            .in_flags     (chain_flags[gi]),
            .in_mn        (chain_mn[gi]),
            .in_mx        (chain_mx[gi]),
            .in_lo        (chain_lo[gi]),
            .in_hi        (chain_hi[gi]),
            .in_free_idx  (chain_free_idx[gi]),
            .out_valid    (chain_valid[gi+1]),
            .out_cmd      (chain_cmd[gi+1]),
            .out_key      (chain_key[gi+1]),
            .out_flags    (chain_flags[gi+1]),
            .out_mn       (chain_mn[gi+1]),
            .out_mx       (chain_mx[gi+1]),
            .out_lo       (chain_lo[gi+1]),
            .out_hi       (chain_hi[gi+1]),
            .out_free_idx (chain_free_idx[gi+1]),
            .wr_en        (insert),
            .wr_idx       (chain_free_idx[MAX_MEMBERS]),
            .wr_key       (chain_key[MAX_MEMBERS])
         );
      end
   endgenerate

   // tail: form the result and commit a new member
   assign tail_valid = chain_valid[MAX_MEMBERS];
   assign tail_flags = chain_flags[MAX_MEMBERS];
   assign table_full = (count_ff == CNT_BITS'(MAX_MEMBERS));
   assign insert     = tail_valid && (chain_cmd[MAX_MEMBERS] == CMD_JOIN)
                       && !tail_flags.member && !table_full && tail_flags.free_found;

   always_comb begin
      pend_status_in  = STATUS_OK;
      pend_owner_in   = '0;
      pend_pred_in    = '0;
      pend_succ_in    = '0;
      pend_already_in = 1'b0;
      if (chain_cmd[MAX_MEMBERS] == CMD_LOOKUP) begin
         if (count_ff == '0) begin
            pend_status_in = STATUS_EMPTY;
         end else if (tail_flags.member) begin
            pend_owner_in = chain_key[MAX_MEMBERS];
         end else if (tail_flags.has_hi) begin
            pend_owner_in = chain_hi[MAX_MEMBERS];
         end else begin
            pend_owner_in = chain_mn[MAX_MEMBERS];
         end
      end else if (!tail_flags.member && table_full) begin
         pend_status_in = STATUS_FULL;
      end else begin
         pend_already_in = tail_flags.member;
         if (!tail_flags.any) begin
            // lone member: it neighbors itself
            pend_pred_in = chain_key[MAX_MEMBERS];
            pend_succ_in = chain_key[MAX_MEMBERS];
         end else begin
            pend_pred_in = tail_flags.has_lo ? chain_lo[MAX_MEMBERS] : chain_mx[MAX_MEMBERS];
            pend_succ_in = tail_flags.has_hi ? chain_hi[MAX_MEMBERS] : chain_mn[MAX_MEMBERS];
         end
      end
   end

   assign count_in = insert ? count_ff + CNT_BITS'(1) : count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // pending result: hold it until the output register frees
   assign pend_move = pend_valid_ff && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (tail_valid) begin
         pend_valid_ff <= 1'b1;
      end else if (pend_move) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (tail_valid) begin
         pend_status_ff  <= pend_status_in;
         pend_owner_ff   <= pend_owner_in;
         pend_pred_ff    <= pend_pred_in;
         pend_succ_ff    <= pend_succ_in;
         pend_already_ff <= pend_already_in;
         pend_count_ff   <= count_in;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (pend_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pend_move) begin
         rsp_status_ff  <= pend_status_ff;
         rsp_owner_ff   <= pend_owner_ff;
         rsp_pred_ff    <= pend_pred_ff;
         rsp_succ_ff    <= pend_succ_ff;
         rsp_already_ff <= pend_already_ff;
         rsp_count_ff   <= pend_count_ff;
      end
   end

   // busy from acceptance until the result leaves the pending stage
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_BUSY;
            end
         end
         ST_BUSY: begin
            if (pend_move) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_owner          = rsp_owner_ff;
   assign rsp_pred_id        = rsp_pred_ff;
   assign rsp_succ_id        = rsp_succ_ff;
   assign rsp_already_member = rsp_already_ff;
   assign rsp_member_count   = rsp_count_ff;

endmodule

@@ hw/rtl/rsl_checker.sv @@
module rsl_checker #(
   parameter int MAX_MEMBERS = 32,
   parameter int KEY_BITS    = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   input  logic                                  req_ready,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   input  logic [rsl_pkg::STATUS_BITS-1:0]       rsp_status,
   input  logic [KEY_BITS-1:0]                   rsp_owner,
   input  logic [KEY_BITS-1:0]                   rsp_pred_id,
   input  logic [KEY_BITS-1:0]                   rsp_succ_id,
   input  logic                                  rsp_already_member,
   input  logic [$clog2(MAX_MEMBERS+1)-1:0]      rsp_member_count
);
   import rsl_pkg::*;

   localparam int CNT_BITS = $clog2(MAX_MEMBERS + 1);

   // an accepted request blocks the next one while it is in flight
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while another is in flight");

   // a stalled transaction holds its status, owner, neighbors and member count
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_owner)
         && $stable(rsp_pred_id) && $stable(rsp_succ_id) && $stable(rsp_member_count))
      else $error("response changed while stalled");

   // a rejected join only happens on a full table and carries no neighbors
   a_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_FULL |->
         rsp_member_count == CNT_BITS'(MAX_MEMBERS) && rsp_pred_id == '0
         && rsp_succ_id == '0 && !rsp_already_member)
      else $error("full status with inconsistent fields");

   // an empty ring lookup reports no members and no owner
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EMPTY |-> rsp_member_count == '0 && rsp_owner == '0)
      else $error("empty status with inconsistent fields");

   // a rejoin is a successful join on a nonempty ring
   a_rejoin: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_already_member |-> rsp_status == STATUS_OK && rsp_member_count != '0
         && rsp_owner == '0)
      else $error("rejoin with inconsistent fields");

endmodule

bind ring_successor_lookup_table_unit rsl_checker #(
   .MAX_MEMBERS (MAX_MEMBERS),
   .KEY_BITS    (KEY_BITS)
) u_rsl_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_status         (rsp_status),
   .rsp_owner          (rsp_owner),
   .rsp_pred_id        (rsp_pred_id),
   .rsp_succ_id        (rsp_succ_id),
   .rsp_already_member (rsp_already_member),
   .rsp_member_count   (rsp_member_count)
);
